### hdl/ssm_pkg.sv
package ssm_pkg;

    // Fixed field widths of the programming interface and the result word.
    localparam int PAT_BYTES  = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 64;
    localparam int LEN_W      = 5;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] t_pattern;

    // Pattern setup shared by every compare cell.
    typedef struct packed {
        t_pattern           pattern;
        logic [LEN_W-1:0]   len;
    } t_cell_cfg;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               end_of_text;
        logic               any_found;
    } t_result;

endpackage

### hdl/ssm_cell.sv
// One window stage: holds one earlier text byte, hands it on to the next
// stage on every accepted word, and checks it against the pattern byte that
// lines up with its place for the current pattern length.
module ssm_cell #(
    parameter int W = 0
) (
    input  logic                       i_clk,
    input  logic                       i_advance,
    input  logic [ssm_pkg::BYTE_W-1:0] i_byte,
    input  ssm_pkg::t_cell_cfg         i_cfg,
    output logic [ssm_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_ok
);

    localparam logic [ssm_pkg::LEN_W-1:0] NEED_LEN = ssm_pkg::LEN_W'(W + 2);

    logic [ssm_pkg::BYTE_W-1:0] r_byte;
    logic [ssm_pkg::LEN_W-1:0]  pat_idx;

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_byte <= i_byte;
        end
    end

    // Window entry W pairs with pattern byte len-2-W; entries past the
    // pattern do not take part.
    assign pat_idx = i_cfg.len - NEED_LEN;
    assign o_ok    = (i_cfg.len < NEED_LEN) || (r_byte == i_cfg.pattern[pat_idx[3:0]]);
    assign o_byte  = r_byte;

endmodule

### hdl/ssm_out_queue.sv
// Small result queue: takes up to two result words per cycle, gives one
// when popped, and is "almost full" when fewer than two slots are free.
module ssm_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_cnt,
    input  ssm_pkg::t_result   i_res_a,
    input  ssm_pkg::t_result   i_res_b,
    input  logic               i_pop,
    output logic               o_valid,
    output ssm_pkg::t_result   o_res,
    output logic               o_almost_full
);

    localparam int PTR_W = $clog2(ssm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ssm_pkg::QUEUE_DEPTH + 1);

    ssm_pkg::t_result   r_mem [ssm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   wr_ptr_b;
    logic               pop_ok;

    assign wr_ptr_b = r_wr_ptr + PTR_W'(1);
    assign pop_ok   = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_cnt);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push_cnt) - CNT_W'(pop_ok);
        end
    end

    assign o_valid       = (r_count != '0);
    assign o_res         = r_mem[r_rd_ptr];
    assign o_almost_full = (r_count > CNT_W'(ssm_pkg::QUEUE_DEPTH - 2));

endmodule

### hdl/substring_stream_matcher_unit.sv
// A result word is written to the output queue as its text word is accepted.
// Throughput: one text word per cycle while o_in_stall is low; a word that gives
// both a match and the end-of-text summary puts two results into the four-entry
// output queue, which drains one per cycle while i_out_stall is low.
// Reset (synchronous, active low) clears the position counter, the found state,
// the output queue, and sets the pattern to zero with a length of one.
module substring_stream_matcher_unit #(
    parameter int PATTERN_MAX = 16,
    parameter int INDEX_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssm_pkg::CFG_W-1:0]     i_cfg_data,
    // Text input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ssm_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                          i_last_byte,
    // Result output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssm_pkg::POS_W-1:0]     o_position,
    output logic                          o_end_of_text,
    output logic                          o_any_found
);

    localparam logic [ssm_pkg::LEN_W-1:0] LEN_MAX = ssm_pkg::LEN_W'(PATTERN_MAX);

    // Configuration registers.
    logic [ssm_pkg::CFG_W-1:0] r_pat_low;
    logic [ssm_pkg::CFG_W-1:0] r_pat_high;
    logic [ssm_pkg::LEN_W-1:0] r_pat_len;

    // Per-text state.
    logic [INDEX_BITS-1:0]     r_count;
    logic                      r_seen;
    logic [INDEX_BITS-1:0]     r_first;
    logic [INDEX_BITS-1:0]     n_count;
    logic                      n_seen;
    logic [INDEX_BITS-1:0]     n_first;

    logic                      accept;
    ssm_pkg::t_cell_cfg        cell_cfg;
    logic [ssm_pkg::LEN_W-1:0] len_eff;
    logic [ssm_pkg::LEN_W-1:0] len_m1;
    logic [INDEX_BITS-1:0]     len_m1_ext;
    logic [INDEX_BITS-1:0]     start;
    logic                      hit;

    logic [PATTERN_MAX-1:0]                        cell_ok;
    logic [PATTERN_MAX:0][ssm_pkg::BYTE_W-1:0]     chain;

    logic [INDEX_BITS+ssm_pkg::POS_W-1:0] start_wide;
    logic [INDEX_BITS+ssm_pkg::POS_W-1:0] first_wide;

    ssm_pkg::t_result          res_a;
    ssm_pkg::t_result          res_b;
    ssm_pkg::t_result          match_res;
    ssm_pkg::t_result          end_res;
    ssm_pkg::t_result          out_res;
    logic [1:0]                push_cnt;
    logic                      almost_full;

    // The input is held off whenever the queue could not take two results.
    assign o_in_stall = almost_full;
    assign accept     = i_in_valid && !almost_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= ssm_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssm_pkg::REG_PATTERN_LOW: begin
                    r_pat_low <= i_cfg_data;
                end
                ssm_pkg::REG_PATTERN_HIGH: begin
                    r_pat_high <= i_cfg_data;
                end
                ssm_pkg::REG_PATTERN_LEN: begin
                    r_pat_len <= i_cfg_data[ssm_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Lengths beyond the window are treated as the longest supported one.
    assign len_eff          = (r_pat_len > LEN_MAX) ? LEN_MAX : r_pat_len;
    assign len_m1           = len_eff - ssm_pkg::LEN_W'(1);
    assign len_m1_ext       = {{(INDEX_BITS - ssm_pkg::LEN_W){1'b0}}, len_m1};
    assign cell_cfg.pattern = {r_pat_high, r_pat_low};
    assign cell_cfg.len     = len_eff;

    // The window is a row of cells; the newest byte enters at the front and
    // every cell passes its byte one place back on each accepted word.
    assign chain[0] = i_text_byte;

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            ssm_cell #(
                .W(g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_advance (accept),
                .i_byte    (chain[g]),
                .i_cfg     (cell_cfg),
                .o_byte    (chain[g+1]),
                .o_ok      (cell_ok[g])
            );
        end
    endgenerate

    // A match needs a nonzero length, enough bytes seen in this text, the
    // current byte equal to the last pattern byte and every active cell in
    // agreement. Window bytes from before the text are never consulted,
    // because the count check keeps the compare inside the text.
    assign hit = (len_eff != '0) && (r_count >= len_m1_ext)
              && (i_text_byte == cell_cfg.pattern[len_m1[3:0]]) && (&cell_ok);

    assign start = r_count - len_m1_ext;

    always_comb begin
        n_seen  = r_seen;
        n_first = r_first;
        if (hit && !r_seen) begin
            n_seen  = 1'b1;
            n_first = start;
        end
        // The counter holds at its top value once it gets there.
        n_count = (r_count != '1) ? (r_count + INDEX_BITS'(1)) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen  <= 1'b0;
            r_first <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_count <= '0;
                r_seen  <= 1'b0;
                r_first <= '0;
            end else begin
                r_count <= n_count;
                r_seen  <= n_seen;
                r_first <= n_first;
            end
        end
    end

    // Positions are reported in their low sixteen bits, zero-extended when
    // the index is narrower.
    assign start_wide = {{ssm_pkg::POS_W{1'b0}}, start};
    assign first_wide = {{ssm_pkg::POS_W{1'b0}}, n_first};

    assign match_res.position    = start_wide[ssm_pkg::POS_W-1:0];
    assign match_res.end_of_text = 1'b0;
    assign match_res.any_found   = 1'b1;

    assign end_res.position      = first_wide[ssm_pkg::POS_W-1:0];
    assign end_res.end_of_text   = 1'b1;
    assign end_res.any_found     = n_seen;

    // The match word always goes ahead of the summary word.
    always_comb begin
        res_a    = match_res;
        res_b    = end_res;
        push_cnt = 2'd0;
        if (accept) begin
            if (hit && i_last_byte) begin
                push_cnt = 2'd2;
            end else if (hit) begin
                push_cnt = 2'd1;
            end else if (i_last_byte) begin
                res_a    = end_res;
                push_cnt = 2'd1;
            end
        end
    end

    ssm_out_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push_cnt    (push_cnt),
        .i_res_a       (res_a),
        .i_res_b       (res_b),
        .i_pop         (!i_out_stall),
        .o_valid       (o_out_valid),
        .o_res         (out_res),
        .o_almost_full (almost_full)
    );

    assign o_position    = out_res.position;
    assign o_end_of_text = out_res.end_of_text;
    assign o_any_found   = out_res.any_found;

endmodule
